// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the palindrome finder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/core/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types and constants of the longest palindrome finder.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Width of a reported 1-based position
  localparam int unsigned POS_W = 13;
  // Width of one text byte
  localparam int unsigned CHAR_W = 8;
  // Width of the packed result word on the output stream
  localparam int unsigned OUT_W = 32;

  // Loader state
  typedef enum logic [1:0] {
    TS_LOAD = 2'b01,
    TS_PASS = 2'b10
  } top_state_e;

  // Expansion sequencer state
  typedef enum logic [6:0] {
    ES_IDLE    = 7'b0000001,
    ES_CENTER  = 7'b0000010,
    ES_MIRROR  = 7'b0000100,
    ES_PROBE   = 7'b0001000,
    ES_COMPARE = 7'b0010000,
    ES_WRITE   = 7'b0100000,
    ES_DONE    = 7'b1000000
  } eng_state_e;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] start_pos;
  } lpf_result_t;

endpackage

// ===== rtl/core/lpf_text_mem.sv =====
// ----------------------------------------------------------------------------
// lpf_text_mem
// Text store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lpf_text_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lpf_pkg::CHAR_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [lpf_pkg::CHAR_W-1:0]  rdata_a_o,
  output logic [lpf_pkg::CHAR_W-1:0]  rdata_b_o
);

  logic [lpf_pkg::CHAR_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/lpf_radius_mem.sv =====
// ----------------------------------------------------------------------------
// lpf_radius_mem
// Radius table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpf_radius_mem #(
  parameter int unsigned DEPTH = 8194,
  parameter int unsigned AW    = 14
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          re_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/lpf_engine.sv =====
// ----------------------------------------------------------------------------
// lpf_engine
// Manacher sequencer over the separator-padded string; owns the radius table.
// ----------------------------------------------------------------------------
module lpf_engine #(
  parameter  int unsigned MAX_LEN = 4096,
  localparam int unsigned LW      = $clog2(MAX_LEN + 1),
  localparam int unsigned TAW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [LW-1:0]             len_i,
  output logic [TAW-1:0]            text_raddr_a_o,
  output logic [TAW-1:0]            text_raddr_b_o,
  input  logic [lpf_pkg::CHAR_W-1:0] text_rdata_a_i,
  input  logic [lpf_pkg::CHAR_W-1:0] text_rdata_b_i,
  output lpf_pkg::lpf_result_t      res_o,
  input  logic                      res_ready_i
);

  localparam int unsigned PW  = $clog2(2 * MAX_LEN + 2);
  localparam int unsigned RD  = 2 * MAX_LEN + 2;
  localparam int unsigned PPW = lpf_pkg::POS_W;

  lpf_pkg::eng_state_e state_q, state_d;

  logic [PW-1:0]  m_q, m_d;        // padded length 2n+1
  logic [PW-1:0]  i_q, i_d;        // current center
  logic [PW-1:0]  f_q, f_d;        // current radius
  logic [PW-1:0]  lim_q, lim_d;    // reach bound on the mirrored radius
  logic [PW-1:0]  rmax_q, rmax_d;  // rightmost reach
  logic [PW-1:0]  ctr_q, ctr_d;    // center owning rmax
  logic [PW-1:0]  bestf_q, bestf_d;
  logic [PPW-1:0] bestl_q, bestl_d;
  logic [PPW-1:0] bestr_q, bestr_d;

  logic [PW:0]   a_w;
  logic [PW-1:0] b_w;
  logic          in_bounds;
  logic [PW-1:0] ta_full, tb_full;
  logic [PW:0]   refl_w;
  logic [PW-1:0] sum_if;
  logic [PW:0]   lsum, rsum;
  logic          rad_we, rad_re;
  logic [PW-1:0] rad_rdata;

  // Probe positions of the next expansion step
  assign a_w       = {1'b0, i_q} + {1'b0, f_q} + (PW+1)'(1);
  assign b_w       = i_q - f_q - PW'(1);
  assign in_bounds = (a_w <= {1'b0, m_q}) && (i_q > (f_q + PW'(1)));
  assign ta_full   = a_w[PW:1] - PW'(1);
  assign tb_full   = {1'b0, b_w[PW-1:1]} - PW'(1);

  assign text_raddr_a_o = ta_full[TAW-1:0];
  assign text_raddr_b_o = tb_full[TAW-1:0];

  assign refl_w = {ctr_q, 1'b0} - {1'b0, i_q};
  assign sum_if = i_q + f_q;
  assign lsum   = {1'b0, i_q} - {1'b0, f_q} + (PW+1)'(1);
  assign rsum   = {1'b0, i_q} + {1'b0, f_q} - (PW+1)'(1);

  assign rad_re = (state_q == lpf_pkg::ES_CENTER);
  assign rad_we = (state_q == lpf_pkg::ES_WRITE);

  lpf_radius_mem #(
    .DEPTH (RD),
    .AW    (PW)
  ) u_lpf_radius_mem (
    .clk_i   (clk_i),
    .we_i    (rad_we),
    .waddr_i (i_q),
    .wdata_i (f_q),
    .raddr_i (refl_w[PW-1:0]),
    .re_i    (rad_re),
    .rdata_o (rad_rdata)
  );

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    i_d     = i_q;
    f_d     = f_q;
    lim_d   = lim_q;
    rmax_d  = rmax_q;
    ctr_d   = ctr_q;
    bestf_d = bestf_q;
    bestl_d = bestl_q;
    bestr_d = bestr_q;
    unique case (state_q)
      lpf_pkg::ES_IDLE: begin
        if (start_i) begin
          m_d     = {len_i, 1'b1};
          i_d     = PW'(1);
          rmax_d  = '0;
          ctr_d   = '0;
          bestf_d = PW'(1);
          bestl_d = PPW'(1);
          bestr_d = PPW'(1);
          state_d = lpf_pkg::ES_CENTER;
        end
      end
      lpf_pkg::ES_CENTER: begin
        // Inside the known reach: start from the mirrored radius
        if (rmax_q >= i_q) begin
          lim_d   = rmax_q - i_q;
          state_d = lpf_pkg::ES_MIRROR;
        end else begin
          f_d     = '0;
          state_d = lpf_pkg::ES_PROBE;
        end
      end
      lpf_pkg::ES_MIRROR: begin
        f_d     = (rad_rdata < lim_q) ? rad_rdata : lim_q;
        state_d = lpf_pkg::ES_PROBE;
      end
      lpf_pkg::ES_PROBE: begin
        if (!in_bounds) begin
          state_d = lpf_pkg::ES_WRITE;
        end else if (a_w[0]) begin
          // Separators always match
          f_d = f_q + PW'(1);
        end else begin
          state_d = lpf_pkg::ES_COMPARE;
        end
      end
      lpf_pkg::ES_COMPARE: begin
        if (text_rdata_a_i == text_rdata_b_i) begin
          f_d     = f_q + PW'(1);
          state_d = lpf_pkg::ES_PROBE;
        end else begin
          state_d = lpf_pkg::ES_WRITE;
        end
      end
      lpf_pkg::ES_WRITE: begin
        if (sum_if > rmax_q) begin
          rmax_d = sum_if;
          ctr_d  = i_q;
        end
        // Palindrome length is f; strictly longer wins, ties keep earliest
        if (f_q > bestf_q) begin
          bestf_d = f_q;
          bestl_d = PPW'(lsum >> 1);
          bestr_d = PPW'(rsum >> 1);
        end
        if (i_q == m_q) begin
          state_d = lpf_pkg::ES_DONE;
        end else begin
          i_d     = i_q + PW'(1);
          state_d = lpf_pkg::ES_CENTER;
        end
      end
      lpf_pkg::ES_DONE: begin
        if (res_ready_i) begin
          state_d = lpf_pkg::ES_IDLE;
        end
      end
      default: begin
        state_d = lpf_pkg::ES_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpf_pkg::ES_IDLE;
      rmax_q  <= '0;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      rmax_q  <= rmax_d;
      ctr_q   <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    i_q     <= i_d;
    f_q     <= f_d;
    lim_q   <= lim_d;
    bestf_q <= bestf_d;
    bestl_q <= bestl_d;
    bestr_q <= bestr_d;
  end

  assign res_o.valid     = (state_q == lpf_pkg::ES_DONE);
  assign res_o.start_pos = bestl_q;
  assign res_o.end_pos   = bestr_q;

endmodule

// ===== rtl/core/longest_palindrome_finder_top.sv =====
// ----------------------------------------------------------------------------
// longest_palindrome_finder_top
// Stores a byte string and reports its first longest palindromic substring.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents (low bit first)
//  s_axis   in         tdata[7:0] char_in, tlast = last byte of the string
//  m_axis   out        tdata[12:0] start_pos, tdata[25:13] end_pos, rest zero
//
//  Bytes load one per cycle into the text store. After the last byte the
//  engine walks the 2n+1 padded positions once; each center passes through
//  ES_CENTER, ES_MIRROR when inside the reach, ES_PROBE and ES_WRITE, with
//  one probe per separator match and a probe and a compare per byte match.
//  Both probe bytes come from the two read ports of the text store at once.
//  s_axis_tready is low from the last byte until the result is registered.
//  A stalled result holds in the output register while loading resumes.
//  Reset clears control state only; the stores hold garbage until written.
//
module longest_palindrome_finder_top #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] char_in
  input  logic                        s_axis_tlast,   // last
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lpf_pkg::OUT_W-1:0]   m_axis_tdata    // [12:0] start_pos, [25:13] end_pos
);

  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned TAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PPW = lpf_pkg::POS_W;

  lpf_pkg::top_state_e state_q, state_d;

  logic [LW-1:0]  len_q, len_d;      // bytes stored for the current string
  logic           accept;
  logic           store;
  logic           start;
  logic [LW-1:0]  len_start;
  logic           out_free;
  logic           out_valid_q;
  logic [PPW-1:0] out_start_q, out_end_q;

  logic [TAW-1:0]             raddr_a, raddr_b;
  logic [lpf_pkg::CHAR_W-1:0] rdata_a, rdata_b;
  lpf_pkg::lpf_result_t       res;

  assign s_axis_tready = (state_q == lpf_pkg::TS_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // Drop bytes beyond the store depth; a dropped last byte still ends the string
  assign store         = accept && (len_q < LW'(MAX_LEN));
  assign start         = accept && s_axis_tlast;
  assign len_start     = store ? (len_q + LW'(1)) : len_q;

  // Output register frees up when empty or taken this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  lpf_text_mem #(
    .DEPTH (MAX_LEN),
    .AW    (TAW)
  ) u_lpf_text_mem (
    .clk_i     (clk_i),
    .we_i      (store),
    .waddr_i   (len_q[TAW-1:0]),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  lpf_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_lpf_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .len_i          (len_start),
    .text_raddr_a_o (raddr_a),
    .text_raddr_b_o (raddr_b),
    .text_rdata_a_i (rdata_a),
    .text_rdata_b_i (rdata_b),
    .res_o          (res),
    .res_ready_i    (out_free)
  );

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    unique case (state_q)
      lpf_pkg::TS_LOAD: begin
        if (store) begin
          len_d = len_q + LW'(1);
        end
        if (start) begin
          // Restart the count for the next string
          len_d   = '0;
          state_d = lpf_pkg::TS_PASS;
        end
      end
      lpf_pkg::TS_PASS: begin
        if (res.valid && out_free) begin
          state_d = lpf_pkg::TS_LOAD;
        end
      end
      default: begin
        state_d = lpf_pkg::TS_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpf_pkg::TS_LOAD;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (res.valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result word; hold it while the sink stalls
  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      out_start_q <= res.start_pos;
      out_end_q   <= res.end_pos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(lpf_pkg::OUT_W - 2 * PPW)'(0), out_end_q, out_start_q};

endmodule

// ===== rtl/core/lpf_checker.sv =====
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks of the longest palindrome finder, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input logic        s_axis_tlast,   // last
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata    // [12:0] start_pos, [25:13] end_pos
);

  logic in_fire;
  logic [7:0] in_char;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_char = s_axis_tdata;

  // A stalled result stays offered
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped while stalled")

  // Intake closes right after the last byte of a string
  `ASSERT_PROP(a_close_after_last, clk_i, rst_ni,
    (in_fire && s_axis_tlast && (in_char == in_char)) |=> !s_axis_tready,
    "byte accepted during the pass")

  // A new result appears only as the pass ends and intake reopens
  `ASSERT_PROP(a_result_reopens, clk_i, rst_ni,
    $rose(m_axis_tvalid) |-> $rose(s_axis_tready), "result without a finished pass")

  // Bounds are 1-based and ordered
  `ASSERT_NEVER(a_bounds_order, clk_i, rst_ni,
    m_axis_tvalid && ((m_axis_tdata[12:0] == 13'd0) ||
                      (m_axis_tdata[25:13] < m_axis_tdata[12:0])),
    "bad palindrome bounds")

endmodule

bind longest_palindrome_finder_top lpf_checker u_lpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/longest_palindrome_finder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_palindrome_finder_top_tb
// Self-checking bench for the longest palindromic substring finder.
// ----------------------------------------------------------------------------
//
//  Strings go in one byte per input word, the final byte flagged by tlast.
//  A scoreboard object keeps its own copy of the text and runs the same
//  center-expansion search over the separator-padded string. It queues one
//  expected span per string and compares every result word against the
//  oldest span: start, end and the unused upper bits.
//
//  Stimulus: a few hand-picked strings (single bytes at both extremes, all
//  distinct bytes, separator-valued bytes, even and odd palindromes, a tie),
//  then random strings with palindrome-heavy content.
//
module longest_palindrome_finder_top_tb;

  localparam int unsigned TEXT_DEPTH   = 4096;
  localparam int unsigned RANDOM_WORDS = 630;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam logic [7:0]  SEP_BYTE     = 8'h23;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [lpf_pkg::POS_W-1:0] start_pos;
    logic [lpf_pkg::POS_W-1:0] end_pos;
  } span_t;

  // --------------------------------------------------------------------------
  // Scoreboard: text copy, span search and the queue of expected spans
  // --------------------------------------------------------------------------
  class palindrome_scoreboard;
    logic [7:0]  text [TEXT_DEPTH];
    int unsigned radius [2*TEXT_DEPTH+2];
    int unsigned fill;
    span_t       span_q[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Odd padded positions are separators; they only match each other.
    function bit pad_match(int unsigned a, int unsigned b);
      if (a[0] || b[0]) return a[0] && b[0];
      return text[a/2-1] == text[b/2-1];
    endfunction

    function span_t longest_span();
      int unsigned width;
      int unsigned reach;
      int unsigned hub;
      int unsigned f;
      int unsigned cap;
      int unsigned twin;
      int          lo;
      int          hi;
      int          best_w;
      span_t       best;
      width  = 2*fill + 1;
      reach  = 0;
      hub    = 0;
      best_w = 0;
      best.start_pos = 1;
      best.end_pos   = 1;
      for (int unsigned i = 1; i <= width; i++) begin
        f = 0;
        // Seed the radius from the mirror center inside the current reach
        if (reach >= i) begin
          twin = 2*hub - i;
          cap  = reach - i;
          f    = (radius[twin] < cap) ? radius[twin] : cap;
        end
        while (i + f + 1 <= width && i > f + 1 && pad_match(i + f + 1, i - f - 1))
          f++;
        radius[i] = f;
        if (i + f > reach) begin
          reach = i + f;
          hub   = i;
        end
      end
      // Strictly longer wins, so the earliest span keeps a tie
      for (int unsigned i = 1; i <= width; i++) begin
        f  = radius[i];
        lo = int'((i - f + 1) / 2);
        hi = int'((i + f - 1) / 2);
        if (hi - lo > best_w) begin
          best_w         = hi - lo;
          best.start_pos = lo[lpf_pkg::POS_W-1:0];
          best.end_pos   = hi[lpf_pkg::POS_W-1:0];
        end
      end
      return best;
    endfunction

    // Store a byte (drop it past the store depth); close the string on last.
    function void note_byte(logic [7:0] ch, logic lst);
      if (fill < TEXT_DEPTH) begin
        text[fill] = ch;
        fill++;
      end
      if (lst) begin
        span_q.push_back(longest_span());
        fill = 0;
      end
    endfunction

    task check_span(logic [lpf_pkg::OUT_W-1:0] word);
      span_t want;
      if (span_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with no string pending", word));
        return;
      end
      want = span_q.pop_front();
      if (word[lpf_pkg::POS_W-1:0] !== want.start_pos)
        report_mismatch($sformatf("start_pos %0d, want %0d",
                                  word[lpf_pkg::POS_W-1:0], want.start_pos));
      if (word[2*lpf_pkg::POS_W-1:lpf_pkg::POS_W] !== want.end_pos)
        report_mismatch($sformatf("end_pos %0d, want %0d",
                                  word[2*lpf_pkg::POS_W-1:lpf_pkg::POS_W],
                                  want.end_pos));
      if (word[lpf_pkg::OUT_W-1:2*lpf_pkg::POS_W] !== '0)
        report_mismatch($sformatf("unused bits %h, want zero",
                                  word[lpf_pkg::OUT_W-1:2*lpf_pkg::POS_W]));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata;    // [7:0] char_in
  logic                      s_axis_tlast;    // last
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [lpf_pkg::OUT_W-1:0] m_axis_tdata;    // [12:0] start_pos, [25:13] end_pos

  palindrome_scoreboard sb = new();

  int unsigned words_sent = 0;
  int unsigned sink_hold  = 0;   // cycles the receiver still holds off
  bit          calm       = 1'b0; // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  longest_palindrome_finder_top #(
    .MAX_LEN (TEXT_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        // Hold ready low so results back up and the input stalls
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Check every accepted result word against the oldest expected span
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_span(m_axis_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks (entered and left at a falling edge)
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] ch, input logic lst);
    // Random gaps ahead of the word
    while (!calm && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(ch, lst);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input text_t s);
    foreach (s[k]) push_byte(s[k], k == s.size() - 1);
  endtask

  // Pause the sender until every expected span has been checked
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.span_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random string, biased toward repeats and embedded palindromes
  function automatic text_t build_text();
    text_t       s;
    text_t       core;
    logic [7:0]  alph [3];
    int unsigned len;
    int unsigned mode;
    int unsigned half;
    logic [7:0]  fill_byte;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    mode = $urandom_range(0, 9);
    foreach (alph[k]) alph[k] = 8'($urandom_range(0, 255));
    fill_byte = 8'($urandom_range(0, 255));
    case (mode)
      0, 1, 2, 3: begin
        // Two or three distinct-ish symbols: lots of short palindromes
        half = $urandom_range(1, 2);
        repeat (len) s.push_back(alph[$urandom_range(0, half)]);
      end
      4, 5: begin
        repeat (len) s.push_back(8'($urandom_range(0, 255)));
      end
      6, 7: begin
        // Random prefix, mirrored core with optional center, random suffix
        half = $urandom_range(1, 12);
        repeat (half) core.push_back(alph[$urandom_range(0, 2)]);
        repeat ($urandom_range(0, 5)) s.push_back(8'($urandom_range(0, 255)));
        foreach (core[k]) s.push_back(core[k]);
        if ($urandom_range(0, 1)) s.push_back(fill_byte);
        for (int k = core.size() - 1; k >= 0; k--) s.push_back(core[k]);
        repeat ($urandom_range(0, 5)) s.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        repeat (len) s.push_back(fill_byte);
      end
      default: begin
        // Separator-valued bytes mixed with one other symbol
        repeat (len) s.push_back($urandom_range(0, 1) ? SEP_BYTE : alph[0]);
      end
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    text_t       t;
    int unsigned base;
    bit          calm_done;
    bit          hold_done;
    int unsigned calm_end;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    calm_done     = 1'b0;
    hold_done     = 1'b0;
    calm_end      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed strings: single bytes at both extremes, all distinct,
    // separator-valued bytes, odd and even palindromes, an equal-length tie
    t = {8'h00};                                   send_text(t);
    t = {8'hFF};                                   send_text(t);
    t = {8'h01, 8'h80, 8'h7F, 8'hFE};              send_text(t);
    t = {SEP_BYTE, SEP_BYTE};                      send_text(t);
    t = {SEP_BYTE, 8'h61, SEP_BYTE};               send_text(t);
    t = {8'h78, 8'h61, 8'h62, 8'h62, 8'h61, 8'h79}; send_text(t);
    t = {8'h61, 8'h62, 8'h61, 8'h63, 8'h64, 8'h63}; send_text(t);
    drain();

    // Random strings, with one idle-free stretch and one long receiver stall
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if (!calm_done && words_sent - base > 200) begin
        calm      = 1'b1;
        calm_done = 1'b1;
        calm_end  = words_sent + 120;
      end
      if (calm && words_sent >= calm_end) calm = 1'b0;
      if (!hold_done && words_sent - base > 400) begin
        // Keep offering strings while results cannot leave
        sink_hold = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      send_text(build_text());
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();

    // Watch for stray results before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.span_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
